// ===== rtl/chlb_pkg.sv =====
package chlb_pkg;

	// Fixed widths and formats
	localparam int CHANNELS       = 2;
	localparam int STAGES         = 2;
	localparam int SAMPLE_BITS    = 24;
	localparam int COEF_BITS      = 25;
	localparam int COEF_FRAC_BITS = 22;
	localparam int STATE_GUARD    = 8;
	localparam int STATE_BITS     = 48;
	localparam int CFG_INDEX_BITS = 3;
	localparam int PC_W           = 4;

	// Configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_HP_ENABLE = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LP_ENABLE = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_HP_GAIN   = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_HP_FB_ONE = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_HP_FB_TWO = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LP_GAIN   = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LP_FB_ONE = 3'd6;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LP_FB_TWO = 3'd7;

	// Beat payloads
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_in;
		logic                          channel_in;
	} in_beat_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_out;
		logic                          channel_out;
	} out_beat_t;

	// Control word fields
	typedef enum logic {
		STG_HP,
		STG_LP
	} stage_e_t;

	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_GAIN_X,
		MUL_A1_Y,
		MUL_A2_Y
	} mul_sel_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_T,   // t <= round(product)
		OP_Y,   // y <= sat(round(t + z1))
		OP_R,   // r <= round(product)
		OP_Z1,  // z1 <= sat(k*t - r + z2), r <= round(product)
		OP_Z2   // z2 <= sat(t - r), x <= y
	} alu_op_t;

	typedef enum logic [1:0] {
		JMP_NONE,
		JMP_SKIP,  // jump to target when the stage is disabled
		JMP_DONE   // hand the sample to the output register
	} jmp_t;

	typedef struct packed {
		stage_e_t        stg;
		mul_sel_t        mul;
		alu_op_t         op;
		jmp_t            jmp;
		logic [PC_W-1:0] target;
	} ucode_t;

	localparam logic [PC_W-1:0] PC_LP_START = 4'd7;
	localparam logic [PC_W-1:0] PC_DONE     = 4'd14;

	// Microprogram: high-pass section, low-pass section, output
	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		w = '{stg: STG_HP, mul: MUL_NONE, op: OP_NONE, jmp: JMP_DONE, target: '0};
		case (pc)
			4'd0:  w = '{STG_HP, MUL_GAIN_X, OP_NONE, JMP_SKIP, PC_LP_START};
			4'd1:  w = '{STG_HP, MUL_NONE,   OP_T,    JMP_NONE, '0};
			4'd2:  w = '{STG_HP, MUL_NONE,   OP_Y,    JMP_NONE, '0};
			4'd3:  w = '{STG_HP, MUL_A1_Y,   OP_NONE, JMP_NONE, '0};
			4'd4:  w = '{STG_HP, MUL_A2_Y,   OP_R,    JMP_NONE, '0};
			4'd5:  w = '{STG_HP, MUL_NONE,   OP_Z1,   JMP_NONE, '0};
			4'd6:  w = '{STG_HP, MUL_NONE,   OP_Z2,   JMP_NONE, '0};
			4'd7:  w = '{STG_LP, MUL_GAIN_X, OP_NONE, JMP_SKIP, PC_DONE};
			4'd8:  w = '{STG_LP, MUL_NONE,   OP_T,    JMP_NONE, '0};
			4'd9:  w = '{STG_LP, MUL_NONE,   OP_Y,    JMP_NONE, '0};
			4'd10: w = '{STG_LP, MUL_A1_Y,   OP_NONE, JMP_NONE, '0};
			4'd11: w = '{STG_LP, MUL_A2_Y,   OP_R,    JMP_NONE, '0};
			4'd12: w = '{STG_LP, MUL_NONE,   OP_Z1,   JMP_NONE, '0};
			4'd13: w = '{STG_LP, MUL_NONE,   OP_Z2,   JMP_NONE, '0};
			default: w = '{STG_LP, MUL_NONE, OP_NONE, JMP_DONE, '0};
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/cascaded_highpass_lowpass_biquad.sv =====
// Input beats are processed one at a time: in_stall stays high while a sample is
// in progress, and the next input beat is taken in the cycle after the result
// moves to the output register.
// One shared 25x24 multiplier, stepped by a 15-word microprogram, sets the rate.
// arst_n clears the coefficients, enables, filter state and handshake flags.
module cascaded_highpass_lowpass_biquad
	import chlb_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [COEF_BITS-1:0]      cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  in_beat_t                  in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output out_beat_t                 out_data
);

	localparam int PROD_W     = COEF_BITS + SAMPLE_BITS;
	localparam int PROD_SHIFT = COEF_FRAC_BITS - STATE_GUARD;
	localparam int T_W        = PROD_W - PROD_SHIFT;
	localparam int SUM_W      = STATE_BITS + 2;

	localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1) <<< (PROD_SHIFT - 1);
	localparam logic signed [SUM_W-1:0]  OUT_HALF  = SUM_W'(1) <<< (STATE_GUARD - 1);
	localparam logic signed [SUM_W-1:0]  SMP_MAX   = (SUM_W'(1) <<< (SAMPLE_BITS - 1)) - 1;
	localparam logic signed [SUM_W-1:0]  SMP_MIN   = -(SUM_W'(1) <<< (SAMPLE_BITS - 1));
	localparam logic signed [SUM_W-1:0]  ST_MAX    = (SUM_W'(1) <<< (STATE_BITS - 1)) - 1;
	localparam logic signed [SUM_W-1:0]  ST_MIN    = -(SUM_W'(1) <<< (STATE_BITS - 1));

	// Configuration registers
	logic                        hp_en_q, lp_en_q;
	logic signed [COEF_BITS-1:0] hp_gain_q, hp_a1_q, hp_a2_q;
	logic signed [COEF_BITS-1:0] lp_gain_q, lp_a1_q, lp_a2_q;

	// Sequencer
	logic            busy_q;
	logic [PC_W-1:0] pc_q;
	ucode_t          cw;
	logic            stage_en;
	logic            out_free;
	logic            in_take;
	logic            done_go;

	// Datapath registers
	logic signed [SAMPLE_BITS-1:0] x_q, y_q;
	logic                          ch_q;
	logic signed [PROD_W-1:0]      p_q;
	logic signed [T_W-1:0]         t_q, r_q;
	logic signed [STATE_BITS-1:0]  z1_q [STAGES][CHANNELS];
	logic signed [STATE_BITS-1:0]  z2_q [STAGES][CHANNELS];
	logic                          out_valid_q;
	out_beat_t                     out_data_q;

	// Datapath nets
	logic signed [COEF_BITS-1:0]   mul_a;
	logic signed [SAMPLE_BITS-1:0] mul_b;
	logic signed [PROD_W-1:0]      prod;
	logic signed [PROD_W-1:0]      p_add, p_shift;
	logic signed [T_W-1:0]         p_rnd;
	logic signed [STATE_BITS-1:0]  z1_rd, z2_rd;
	logic signed [SUM_W-1:0]       o_sum, o_shift;
	logic signed [SAMPLE_BITS-1:0] y_sat;
	logic signed [SUM_W-1:0]       kt, n1, n2;
	logic signed [STATE_BITS-1:0]  n1_sat, n2_sat;

	assign cw       = ucode_rom(pc_q);
	assign stage_en = (cw.stg == STG_LP) ? lp_en_q : hp_en_q;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = busy_q;
	assign in_take  = in_valid && !busy_q;
	assign done_go  = busy_q && (cw.jmp == JMP_DONE) && out_free;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_en_q   <= 1'b0;
			lp_en_q   <= 1'b0;
			hp_gain_q <= '0;
			hp_a1_q   <= '0;
			hp_a2_q   <= '0;
			lp_gain_q <= '0;
			lp_a1_q   <= '0;
			lp_a2_q   <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_HP_ENABLE: hp_en_q   <= cfg_data[0];
				REG_LP_ENABLE: lp_en_q   <= cfg_data[0];
				REG_HP_GAIN:   hp_gain_q <= cfg_data;
				REG_HP_FB_ONE: hp_a1_q   <= cfg_data;
				REG_HP_FB_TWO: hp_a2_q   <= cfg_data;
				REG_LP_GAIN:   lp_gain_q <= cfg_data;
				REG_LP_FB_ONE: lp_a1_q   <= cfg_data;
				REG_LP_FB_TWO: lp_a2_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Step counter with conditional jumps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
		end else if (!busy_q) begin
			if (in_take) begin
				busy_q <= 1'b1;
				pc_q   <= '0;
			end
		end else begin
			case (cw.jmp)
				JMP_SKIP: pc_q <= stage_en ? pc_q + 1'b1 : cw.target;
				JMP_DONE: begin
					if (out_free) busy_q <= 1'b0;
				end
				default:  pc_q <= pc_q + 1'b1;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_go) begin
			out_data_q.sample_out  <= x_q;
			out_data_q.channel_out <= ch_q;
		end
	end

	// Shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = y_q;
		case (cw.mul)
			MUL_GAIN_X: begin
				mul_a = (cw.stg == STG_LP) ? lp_gain_q : hp_gain_q;
				mul_b = x_q;
			end
			MUL_A1_Y: mul_a = (cw.stg == STG_LP) ? lp_a1_q : hp_a1_q;
			MUL_A2_Y: mul_a = (cw.stg == STG_LP) ? lp_a2_q : hp_a2_q;
			default:  mul_a = '0;
		endcase
	end

	assign prod = mul_a * mul_b;

	// Round the registered product to state units (half up)
	assign p_add   = p_q + PROD_HALF;
	assign p_shift = p_add >>> PROD_SHIFT;
	assign p_rnd   = p_shift[T_W-1:0];

	assign z1_rd = z1_q[cw.stg][ch_q];
	assign z2_rd = z2_q[cw.stg][ch_q];

	// Section output: round t + z1 to sample units, saturate
	assign o_sum   = SUM_W'(t_q) + SUM_W'(z1_rd) + OUT_HALF;
	assign o_shift = o_sum >>> STATE_GUARD;

	always_comb begin
		if (o_shift > SMP_MAX)      y_sat = SMP_MAX[SAMPLE_BITS-1:0];
		else if (o_shift < SMP_MIN) y_sat = SMP_MIN[SAMPLE_BITS-1:0];
		else                        y_sat = o_shift[SAMPLE_BITS-1:0];
	end

	// State update: high-pass uses -2t, low-pass +2t
	assign kt = (cw.stg == STG_LP) ? (SUM_W'(t_q) <<< 1) : -(SUM_W'(t_q) <<< 1);
	assign n1 = kt - SUM_W'(r_q) + SUM_W'(z2_rd);
	assign n2 = SUM_W'(t_q) - SUM_W'(r_q);

	always_comb begin
		if (n1 > ST_MAX)      n1_sat = ST_MAX[STATE_BITS-1:0];
		else if (n1 < ST_MIN) n1_sat = ST_MIN[STATE_BITS-1:0];
		else                  n1_sat = n1[STATE_BITS-1:0];
		if (n2 > ST_MAX)      n2_sat = ST_MAX[STATE_BITS-1:0];
		else if (n2 < ST_MIN) n2_sat = ST_MIN[STATE_BITS-1:0];
		else                  n2_sat = n2[STATE_BITS-1:0];
	end

	// Working registers driven by the control word
	always_ff @(posedge clk) begin
		if (in_take) begin
			x_q  <= in_data.sample_in;
			ch_q <= in_data.channel_in;
		end else if (busy_q) begin
			if (cw.mul != MUL_NONE) p_q <= prod;
			case (cw.op)
				OP_T:  t_q <= p_rnd;
				OP_Y:  y_q <= y_sat;
				OP_R:  r_q <= p_rnd;
				OP_Z1: r_q <= p_rnd;
				OP_Z2: x_q <= y_q;
				default: ;
			endcase
		end
	end

	// Per-section, per-channel delay state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < STAGES; s++) begin
				for (int c = 0; c < CHANNELS; c++) begin
					z1_q[s][c] <= '0;
					z2_q[s][c] <= '0;
				end
			end
		end else if (busy_q) begin
			case (cw.op)
				OP_Z1: z1_q[cw.stg][ch_q] <= n1_sat;
				OP_Z2: z2_q[cw.stg][ch_q] <= n2_sat;
				default: ;
			endcase
		end
	end

endmodule
